// ----- hdl/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// sse_pkg
// Shared widths, payload types and controller commands for the sample
// statistics engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int MAX_SAMPLES = 16;

  localparam int SMP_W  = 16;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int SQ_W   = 2 * SMP_W + CNT_W;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int DVS_W  = 2 * CNT_W;
  localparam int ROOT_W = 16;
  localparam int VAR_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic signed [15:0] average;
    logic        [15:0] deviation;
    logic        [4:0]  sample_count;
    logic               overflowed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // take in_item into the run
    logic mul;          // n*sumsq, sum^2, n^2
    logic ld_mean;      // numerator, load divider with |sum| / n
    logic div_step;     // one quotient bit
    logic ld_var;       // save mean, load divider with num / n^2
    logic sqrt_ld;      // load root unit with variance
    logic sqrt_step;    // one root bit
    logic out_load;     // load result register, clear the run
  } cmd_t;

endpackage

// ----- hdl/sample_statistics_engine_top.sv -----
// ----------------------------------------------------------------------------
// sample_statistics_engine_top
// Running min / max / mean / population standard deviation over runs of
// signed Q8.8 samples.
//
// Input channel in_valid / in_ready / in_item carries one sample per item;
// in_item.last closes the run. Up to MAX_SAMPLES samples are accumulated,
// later ones are dropped and reported through out_item.overflowed.
// While a run is open, one item is taken per cycle. After the last item the
// input closes while the bit-serial divider runs twice (mean, then
// variance) and the square-root unit takes 16 steps. The result is then
// loaded into the output register, out_valid rises and the input reopens
// for the next run.
// The output register holds one result; the next run can be accumulated
// while it waits. If the receiver still stalls when the next run's result
// is ready, the block holds in its final state with the input closed.
// Synchronous reset (rst_n low) clears the run and drops any pending result.
// ----------------------------------------------------------------------------
module sample_statistics_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sse_pkg::out_item_t out_item
);
  import sse_pkg::*;

  cmd_t cmd;

  sse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sse_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ----- hdl/sse_ctrl.sv -----
// ----------------------------------------------------------------------------
// sse_ctrl
// Sequencer: accumulation phase, then multiply, divide (mean and variance),
// square root and result hand-off.
// ----------------------------------------------------------------------------
module sse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sse_pkg::cmd_t cmd
);
  import sse_pkg::*;

  typedef enum logic [9:0] {
    S_ACC   = 10'b00_0000_0001,
    S_FLUSH = 10'b00_0000_0010,
    S_MUL   = 10'b00_0000_0100,
    S_SUB   = 10'b00_0000_1000,
    S_DIVM  = 10'b00_0001_0000,
    S_MSAVE = 10'b00_0010_0000,
    S_DIVV  = 10'b00_0100_0000,
    S_SQLD  = 10'b00_1000_0000,
    S_SQRT  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               div_last, sqrt_last, slot_free;

  assign div_last  = (cnt_r == STEP_W'(NUM_W - 1));
  assign sqrt_last = (cnt_r == STEP_W'(ROOT_W - 1));
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_ACC);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_ACC: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      // lets the last square land in the sum of squares
      S_FLUSH: state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.ld_mean = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_DIVM;
      end
      S_DIVM: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_W'(1);
        if (div_last) begin
          state_nxt = S_MSAVE;
        end
      end
      S_MSAVE: begin
        cmd.ld_var = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIVV;
      end
      S_DIVV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_W'(1);
        if (div_last) begin
          state_nxt = S_SQLD;
        end
      end
      S_SQLD: begin
        cmd.sqrt_ld = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + STEP_W'(1);
        if (sqrt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result was still waiting");

  // the last item of a run closes the input until the result is loaded
  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after the last item of a run");

  // every load of the result raises out_valid
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded without out_valid");

  // step counter stays inside the divider length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (cnt_r <= STEP_W'(NUM_W - 1)))
    else $error("divider step counter out of range");

endmodule

// ----- hdl/sse_dp.sv -----
// ----------------------------------------------------------------------------
// sse_dp
// Datapath: run accumulators, final multipliers, bit-serial divider,
// two-bit-per-step square root and the result register.
// ----------------------------------------------------------------------------
module sse_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sse_pkg::cmd_t      cmd,
  input  sse_pkg::in_item_t  in_item,
  output sse_pkg::out_item_t out_item
);
  import sse_pkg::*;

  // run accumulators
  logic signed [15:0]     min_r, max_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]        sumsq_r;
  logic [CNT_W-1:0]       count_r;
  logic                   drop_r;
  logic [31:0]            sq_r;
  logic                   sq_pend_r;

  // final arithmetic
  logic [NUM_W-1:0]       prod_a_r, prod_b_r, num_r;
  logic [DVS_W-1:0]       nsq_r;
  logic [NUM_W-1:0]       dvd_r;
  logic [DVS_W-1:0]       rem_r, dvs_r;
  logic                   neg_r;
  logic [15:0]            mean_r;
  logic [VAR_W-1:0]       sq_v_r;
  logic [REM_W-1:0]       sq_rem_r;
  logic [ROOT_W-1:0]      root_r;
  out_item_t              out_r;

  logic signed [15:0]     x;
  logic signed [31:0]     x_sq;
  logic                   count_full;
  logic [SUM_W-1:0]       abs_sum;
  logic [NUM_W-1:0]       mul_a, mul_b;
  logic [DVS_W-1:0]       mul_n;
  logic [DVS_W:0]         div_try, div_diff;
  logic                   div_ge;
  logic [15:0]            quot16;
  logic [REM_W+1:0]       rt_try, rt_sub;
  logic                   rt_ge;

  assign x          = in_item.sample;
  assign x_sq       = 32'(x) * 32'(x);
  assign count_full = (count_r == CNT_W'(MAX_SAMPLES));
  assign abs_sum    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign mul_a = NUM_W'(count_r) * NUM_W'(sumsq_r);
  assign mul_b = NUM_W'(abs_sum) * NUM_W'(abs_sum);
  assign mul_n = DVS_W'(count_r) * DVS_W'(count_r);

  // restoring divide: one quotient bit per cycle, quotient shifts into dvd_r
  assign div_try  = {rem_r, dvd_r[NUM_W-1]};
  assign div_diff = div_try - {1'b0, dvs_r};
  assign div_ge   = (div_try >= {1'b0, dvs_r});
  assign quot16   = dvd_r[15:0];

  // digit-by-digit root, two radicand bits per step
  assign rt_try = {sq_rem_r, sq_v_r[VAR_W-1 -: 2]};
  assign rt_sub = (REM_W + 2)'({root_r, 2'b01});
  assign rt_ge  = (rt_try >= rt_sub);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= '0;
      max_r     <= '0;
      sum_r     <= '0;
      sumsq_r   <= '0;
      count_r   <= '0;
      drop_r    <= 1'b0;
      sq_pend_r <= 1'b0;
    end else begin
      sq_pend_r <= 1'b0;
      if (sq_pend_r) begin
        sumsq_r <= sumsq_r + SQ_W'(sq_r);
      end
      if (cmd.accept) begin
        if (!count_full) begin
          if (count_r == '0) begin
            min_r <= x;
            max_r <= x;
          end else begin
            if (x < min_r) min_r <= x;
            if (x > max_r) max_r <= x;
          end
          sum_r     <= sum_r + SUM_W'(x);
          count_r   <= count_r + CNT_W'(1);
          sq_r      <= x_sq;
          sq_pend_r <= 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        min_r   <= '0;
        max_r   <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
        count_r <= '0;
        drop_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_a_r <= mul_a;
      prod_b_r <= mul_b;
      nsq_r    <= mul_n;
    end
    if (cmd.ld_mean) begin
      num_r <= prod_a_r - prod_b_r;
      dvd_r <= NUM_W'(abs_sum);
      dvs_r <= DVS_W'(count_r);
      rem_r <= '0;
      neg_r <= sum_r[SUM_W-1];
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[DVS_W-1:0] : div_try[DVS_W-1:0];
      dvd_r <= {dvd_r[NUM_W-2:0], div_ge};
    end
    if (cmd.ld_var) begin
      mean_r <= neg_r ? 16'(-quot16) : quot16;
      dvd_r  <= num_r;
      dvs_r  <= nsq_r;
      rem_r  <= '0;
    end
    if (cmd.sqrt_ld) begin
      sq_v_r   <= dvd_r[VAR_W-1:0];
      sq_rem_r <= '0;
      root_r   <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_rem_r <= rt_ge ? REM_W'(rt_try - rt_sub) : REM_W'(rt_try);
      root_r   <= {root_r[ROOT_W-2:0], rt_ge};
      sq_v_r   <= {sq_v_r[VAR_W-3:0], 2'b00};
    end
    if (cmd.out_load) begin
      out_r.minimum      <= min_r;
      out_r.maximum      <= max_r;
      out_r.average      <= mean_r;
      out_r.deviation    <= root_r;
      out_r.sample_count <= 5'(count_r);
      out_r.overflowed   <= drop_r;
    end
  end

  assign out_item = out_r;

endmodule
